// ----- src/tppd_pkg.sv -----
package tppd_pkg;

	localparam int CHANNELS = 64;
	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [7:0] CHAN_MASK = 8'h3f;
	localparam logic [7:0] NEW_MASK_BIT = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       pattern_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] row;
		logic [5:0] channel;
		logic [7:0] mask;
		logic [7:0] note;
		logic [7:0] instrument;
		logic [7:0] vol_pan;
		logic [7:0] command;
		logic [7:0] command_value;
	} out_item_t;

	// write / clear request from the parser to the mask store
	typedef struct packed {
		logic       en;
		logic [5:0] addr;
		logic [7:0] data;
		logic       clr;
	} mask_wr_t;

endpackage

// ----- src/tracker_packed_pattern_decoder_top.sv -----
// Path: an accepted request reaches out_item via the input register, then the
// result register. Throughput: one byte per cycle unless out_ready stalls the
// output; the per-channel mask read is launched when the byte is accepted, so
// it is ready in the stage. Reset: arst_n clears parser, row, masks' valid
// bits and both valid flags; pattern_start clears all but the flags first.
module tracker_packed_pattern_decoder_top import tppd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	typedef enum logic [6:0] {
		PH_CHAN = 7'b0000001,
		PH_MASK = 7'b0000010,
		PH_NOTE = 7'b0000100,
		PH_INST = 7'b0001000,
		PH_VOLP = 7'b0010000,
		PH_CMD  = 7'b0100000,
		PH_CVAL = 7'b1000000
	} phase_t;

	function automatic phase_t first_field(input logic [3:0] m, input logic [2:0] from);
		phase_t p;
		logic   found;
		p = PH_CHAN;
		found = 1'b0;
		for (int b = 0; b < 4; b++) begin
			if (!found && (3'(b) >= from) && m[b]) begin
				found = 1'b1;
				case (b)
					0: p = PH_NOTE;
					1: p = PH_INST;
					2: p = PH_VOLP;
					default: p = PH_CMD;
				endcase
			end
		end
		return p;
	endfunction

	logic            s1_valid;
	in_item_t        item_s1;
	logic            s1_adv;

	phase_t          phase_q;
	logic [5:0]      chan_q;
	logic [7:0]      mask_q;
	logic [7:0]      row_q;
	logic [3:0][7:0] held_q;

	phase_t          n_phase;
	logic [5:0]      n_chan;
	logic [7:0]      n_mask;
	logic [7:0]      n_row;
	logic [3:0][7:0] n_held;
	logic [7:0]      n_cval;
	logic            emit;
	logic            chan_ok;
	logic [7:0]      byte_m1;
	logic [7:0]      rd_mask;
	logic [5:0]      rd_addr;
	mask_wr_t        wr;
	out_item_t       ev;

	assign s1_adv   = s1_valid && (!out_valid || out_ready);
	assign in_ready = !s1_valid || s1_adv;

	assign byte_m1  = in_item.data_byte - 8'd1;
	assign rd_addr  = byte_m1[5:0];

	tppd_mask_store u_mask_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_valid && in_ready),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_mask (rd_mask)
	);

	always_comb begin
		logic [7:0] b;
		logic [7:0] cm1;
		phase_t     ph;
		b   = item_s1.data_byte;
		cm1 = b - 8'd1;
		if (item_s1.pattern_start) begin
			ph     = PH_CHAN;
			n_chan = '0;
			n_mask = '0;
			n_row  = '0;
			n_held = '0;
		end else begin
			ph     = phase_q;
			n_chan = chan_q;
			n_mask = mask_q;
			n_row  = row_q;
			n_held = held_q;
		end
		n_phase = PH_CHAN;
		n_cval  = '0;
		emit    = 1'b0;
		chan_ok = ({1'b0, n_chan} < 7'(CHANNELS));
		wr.en   = 1'b0;
		wr.addr = n_chan;
		wr.data = b;
		wr.clr  = s1_adv && item_s1.pattern_start;
		case (ph)
			PH_MASK: begin
				n_mask  = b;
				wr.en   = s1_adv && chan_ok;
				n_phase = first_field(b[3:0], 3'd0);
				emit    = (n_phase == PH_CHAN);
			end
			PH_NOTE: begin
				n_held[0] = b;
				n_phase   = first_field(n_mask[3:0], 3'd1);
				emit      = (n_phase == PH_CHAN);
			end
			PH_INST: begin
				n_held[1] = b;
				n_phase   = first_field(n_mask[3:0], 3'd2);
				emit      = (n_phase == PH_CHAN);
			end
			PH_VOLP: begin
				n_held[2] = b;
				n_phase   = first_field(n_mask[3:0], 3'd3);
				emit      = (n_phase == PH_CHAN);
			end
			PH_CMD: begin
				n_held[3] = b;
				n_phase   = PH_CVAL;
			end
			PH_CVAL: begin
				n_cval = b;
				emit   = 1'b1;
			end
			default: begin
				if (b == 8'h00) begin
					n_row = n_row + 8'd1;
				end else begin
					n_chan  = cm1[5:0] & CHAN_MASK[5:0];
					n_held  = '0;
					chan_ok = ({1'b0, n_chan} < 7'(CHANNELS));
					if ((b & NEW_MASK_BIT) != 8'h00) begin
						n_phase = PH_MASK;
					end else begin
						// reused mask; a pattern start has just wiped the table
						n_mask  = (chan_ok && !item_s1.pattern_start) ? rd_mask : 8'h00;
						n_phase = first_field(n_mask[3:0], 3'd0);
						emit    = (n_phase == PH_CHAN);
					end
				end
			end
		endcase
		ev.row           = n_row;
		ev.channel       = n_chan;
		ev.mask          = n_mask;
		ev.note          = n_held[0];
		ev.instrument    = n_held[1];
		ev.vol_pan       = n_held[2];
		ev.command       = n_held[3];
		ev.command_value = n_cval;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CHAN;
			chan_q  <= '0;
			mask_q  <= '0;
			row_q   <= '0;
			held_q  <= '0;
		end else if (s1_adv) begin
			phase_q <= n_phase;
			chan_q  <= n_chan;
			mask_q  <= n_mask;
			row_q   <= n_row;
			held_q  <= n_held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			out_item <= ev;
		end
	end

endmodule

// ----- src/tppd_mask_store.sv -----
module tppd_mask_store import tppd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rd_en,
	input  logic [5:0] rd_addr,
	input  mask_wr_t   wr,
	output logic [7:0] rd_mask
);

	logic [7:0]          mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	logic [7:0]          rd_q;
	logic                rdv_q;
	logic                same_addr;

	assign same_addr = wr.en && (wr.addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr[CH_AW-1:0]] <= wr.data;
		end
	end

	// read of the incoming byte's channel; a same-edge write is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= same_addr ? wr.data : mem[rd_addr[CH_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q <= 1'b0;
		end else if (rd_en) begin
			rdv_q <= same_addr || (!wr.clr && vld_q[rd_addr[CH_AW-1:0]]);
		end
	end

	// entries never written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.clr) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.addr[CH_AW-1:0]] <= 1'b1;
		end
	end

	assign rd_mask = rdv_q ? rd_q : 8'h00;

endmodule
